// ===== hw/rtl/lirs_pkg.sv =====
// Shared types and constants of the linear interpolation resampler.
package lirs_pkg;

    // Results that one source word may cause at most.
    localparam int MAX_RESULTS = 34;
    localparam int CNT_BITS    = 6;
    localparam int CFG_IDX_BITS = 2;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_STEP    = 2'd0,
        REG_SRC_LEN = 2'd1,
        REG_TGT_LEN = 2'd2
    } lirs_reg_idx_t;

    typedef enum logic {
        FE_IDLE = 1'b0,
        FE_GEN  = 1'b1
    } lirs_fe_state_t;

    // Marks carried along with each output command.
    typedef struct packed {
        logic run_last;
        logic block_done;
    } lirs_tag_t;

endpackage

// ===== hw/rtl/linear_interp_resampler.sv =====
// Top level of the linear interpolation sample-rate converter.
//
//  channel  | direction | handshake               | contents
//  ---------+-----------+-------------------------+---------------------------------
//  s_       | in        | s_tvalid / s_tready     | source sample word
//  m_       | out       | m_tvalid / m_tready     | output sample, run and block marks
//  cfg_     | in        | cfg_valid / cfg_ready   | register index and write data
//
//  A source word is taken in the idle state, then the sequencer issues one output
//  command per cycle while the queue is not full, up to the cap of 34 results
//  per word. Commands pass a 4-deep queue into a 5-stage multiply pipeline,
//  and results leave it at one a cycle while the output words are taken.
//  Reset is synchronous and active low; no clearing pass is needed.
//  A full queue halts the sequencer; an untaken output word freezes the pipe.
module linear_interp_resampler
    import lirs_pkg::*;
#(
    parameter int SAMPLE_BITS = 24,
    parameter int FRAC_BITS   = 16,
    parameter int LENGTH_BITS = 16,
    localparam int TDW        = ((SAMPLE_BITS + 7) / 8) * 8,
    localparam int CFG_BITS   = (FRAC_BITS + 5 > LENGTH_BITS) ? FRAC_BITS + 5 : LENGTH_BITS
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    // source stream
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [TDW-1:0]          s_tdata,   // sample_in
    // result stream
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [TDW-1:0]          m_tdata,   // sample_out
    output logic                    m_tlast,   // run_last
    output logic                    m_tuser,   // block_done
    // register writes: 0 step, 1 source_length, 2 target_length
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [CFG_BITS-1:0]     cfg_data
);

    localparam int TAGW     = $bits(lirs_tag_t);
    localparam int QW       = TAGW + FRAC_BITS + 2 * SAMPLE_BITS;
    localparam int QDEPTH   = 4;

    logic                   push, pop, full, empty;
    logic [SAMPLE_BITS-1:0] f_left, f_right, b_left, b_right;
    logic [FRAC_BITS-1:0]   f_frac, b_frac;
    lirs_tag_t              f_tag, b_tag, o_tag;
    logic [FRAC_BITS+4:0]   step;
    logic [QW-1:0]          q_in, q_out;
    logic [SAMPLE_BITS-1:0] o_sample;

    lirs_front #(
        .SAMPLE_BITS(SAMPLE_BITS),
        .FRAC_BITS  (FRAC_BITS),
        .LENGTH_BITS(LENGTH_BITS),
        .CFG_BITS   (CFG_BITS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_sample (s_tdata[SAMPLE_BITS-1:0]),
        .cmd_push (push),
        .cmd_left (f_left),
        .cmd_right(f_right),
        .cmd_frac (f_frac),
        .cmd_tag  (f_tag),
        .cmd_full (full),
        .step_out (step)
    );

    assign q_in = {f_tag, f_frac, f_right, f_left};

    lirs_cmd_fifo #(
        .WIDTH(QW),
        .DEPTH(QDEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_data(q_in),
        .full     (full),
        .pop      (pop),
        .pop_data (q_out),
        .empty    (empty)
    );

    assign {b_tag, b_frac, b_right, b_left} = q_out;

    lirs_back #(
        .SAMPLE_BITS(SAMPLE_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_empty (empty),
        .cmd_pop   (pop),
        .cmd_left  (b_left),
        .cmd_right (b_right),
        .cmd_frac  (b_frac),
        .cmd_tag   (b_tag),
        .step      (step),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_sample(o_sample),
        .out_tag   (o_tag)
    );

    assign m_tdata = TDW'(o_sample);
    assign m_tlast = o_tag.run_last;
    assign m_tuser = o_tag.block_done;

endmodule

// ===== hw/rtl/lirs_cmd_fifo.sv =====
// Short command queue between the sequencer and the arithmetic pipeline.
module lirs_cmd_fifo
    import lirs_pkg::*;
#(
    parameter int WIDTH = 58,
    parameter int DEPTH = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("command queue count beyond depth");

endmodule

// ===== hw/rtl/lirs_front.sv =====
// Sequencer: configuration registers, read position tracking, command issue.
module lirs_front
    import lirs_pkg::*;
#(
    parameter int SAMPLE_BITS = 24,
    parameter int FRAC_BITS   = 16,
    parameter int LENGTH_BITS = 16,
    parameter int CFG_BITS    = 21
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    // config write channel
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [CFG_BITS-1:0]     cfg_data,
    // source words
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [SAMPLE_BITS-1:0]  s_sample,
    // commands toward the queue
    output logic                    cmd_push,
    output logic [SAMPLE_BITS-1:0]  cmd_left,
    output logic [SAMPLE_BITS-1:0]  cmd_right,
    output logic [FRAC_BITS-1:0]    cmd_frac,
    output lirs_tag_t               cmd_tag,
    input  logic                    cmd_full,
    output logic [FRAC_BITS+4:0]    step_out
);

    localparam int SW = FRAC_BITS + 5;
    localparam int PW = LENGTH_BITS + FRAC_BITS;

    lirs_fe_state_t state_reg, state_next;

    logic [SW-1:0]          step_reg;
    logic [LENGTH_BITS-1:0] src_len_reg, tgt_len_reg;

    logic [SAMPLE_BITS-1:0] prev_reg, prev_next;
    logic [SAMPLE_BITS-1:0] cur_reg, cur_next;
    logic [LENGTH_BITS-1:0] count_reg, count_next;
    logic [PW-1:0]          pos_reg, pos_next;
    logic [LENGTH_BITS-1:0] em_reg, em_next;
    logic [CNT_BITS-1:0]    k_reg, k_next;
    logic                   last_reg, last_next;

    logic [PW:0]            pos_sum;
    logic [PW-1:0]          pos_sat, pos_after;
    logic [LENGTH_BITS-1:0] idx, idx_after, em_after;
    logic [CNT_BITS-1:0]    k_after;
    logic                   idx_lt, idx_eq, idx_after_lt;
    logic                   cond_now, cond_next, finish;

    // position bookkeeping
    assign idx      = pos_reg[PW-1:FRAC_BITS];
    assign idx_lt   = idx < count_reg;
    assign idx_eq   = idx == count_reg;
    assign pos_sum  = {1'b0, pos_reg} + (PW + 1)'(step_reg);
    assign pos_sat  = pos_sum[PW] ? '1 : pos_sum[PW-1:0];
    // past the block end the position holds still
    assign pos_after    = (idx_lt || idx_eq) ? pos_sat : pos_reg;
    assign idx_after    = pos_after[PW-1:FRAC_BITS];
    assign idx_after_lt = idx_after < count_reg;
    assign em_after     = em_reg + 1'b1;
    assign k_after      = k_reg + 1'b1;

    assign cond_now  = (k_reg < CNT_BITS'(MAX_RESULTS)) && (em_reg < tgt_len_reg)
                       && (idx_lt || last_reg);
    assign cond_next = (k_after < CNT_BITS'(MAX_RESULTS)) && (em_after < tgt_len_reg)
                       && (idx_after_lt || last_reg);

    // command payload; beyond the block both neighbors are zero
    assign cmd_left  = idx_lt ? prev_reg : (idx_eq ? cur_reg : '0);
    assign cmd_right = idx_lt ? cur_reg : '0;
    assign cmd_frac  = pos_reg[FRAC_BITS-1:0];
    assign cmd_tag.run_last   = !cond_next;
    assign cmd_tag.block_done = (em_after >= tgt_len_reg) || (last_reg && !cond_next);

    assign cfg_ready = 1'b1;
    assign step_out  = step_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            FE_IDLE: if (s_tvalid) state_next = FE_GEN;
            FE_GEN:  if (finish) state_next = FE_IDLE;
            default: state_next = FE_IDLE;
        endcase
    end

    always_comb begin
        s_tready   = 1'b0;
        cmd_push   = 1'b0;
        finish     = 1'b0;
        prev_next  = prev_reg;
        cur_next   = cur_reg;
        count_next = count_reg;
        pos_next   = pos_reg;
        em_next    = em_reg;
        k_next     = k_reg;
        last_next  = last_reg;
        unique case (state_reg)
            FE_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cur_next  = s_sample;
                    last_next = ({1'b0, count_reg} + 1'b1) >= {1'b0, src_len_reg};
                    k_next    = '0;
                end
            end
            FE_GEN: begin
                if (!cond_now) begin
                    finish = 1'b1;
                end else if (!cmd_full) begin
                    cmd_push = 1'b1;
                    pos_next = pos_after;
                    em_next  = em_after;
                    k_next   = k_after;
                    finish   = !cond_next;
                end
                if (finish) begin
                    if (last_reg) begin
                        prev_next  = '0;
                        count_next = '0;
                        pos_next   = '0;
                        em_next    = '0;
                    end else begin
                        prev_next  = cur_reg;
                        count_next = count_reg + 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg    <= {{4{1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
            src_len_reg <= {{(LENGTH_BITS-1){1'b0}}, 1'b1};
            tgt_len_reg <= {{(LENGTH_BITS-1){1'b0}}, 1'b1};
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_STEP:    step_reg    <= cfg_data[SW-1:0];
                REG_SRC_LEN: src_len_reg <= cfg_data[LENGTH_BITS-1:0];
                REG_TGT_LEN: tgt_len_reg <= cfg_data[LENGTH_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= FE_IDLE;
            prev_reg  <= '0;
            count_reg <= '0;
            pos_reg   <= '0;
            em_reg    <= '0;
            k_reg     <= '0;
            last_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            prev_reg  <= prev_next;
            count_reg <= count_next;
            pos_reg   <= pos_next;
            em_reg    <= em_next;
            k_reg     <= k_next;
            last_reg  <= last_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg <= cur_next;
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        k_reg <= CNT_BITS'(MAX_RESULTS))
        else $error("result count per word beyond limit");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd_push && cmd_tag.run_last) |=> (state_reg == FE_IDLE))
        else $error("sequencer kept running after the last result of a word");

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_push |-> (!cmd_full && state_reg == FE_GEN))
        else $error("command issued into a full queue or outside generation");

endmodule

// ===== hw/rtl/lirs_back.sv =====
// Arithmetic pipeline: interpolate, round, scale by step, round, saturate.
module lirs_back
    import lirs_pkg::*;
#(
    parameter int SAMPLE_BITS = 24,
    parameter int FRAC_BITS   = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cmd_empty,
    output logic                   cmd_pop,
    input  logic [SAMPLE_BITS-1:0] cmd_left,
    input  logic [SAMPLE_BITS-1:0] cmd_right,
    input  logic [FRAC_BITS-1:0]   cmd_frac,
    input  lirs_tag_t              cmd_tag,
    input  logic [FRAC_BITS+4:0]   step,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [SAMPLE_BITS-1:0] out_sample,
    output lirs_tag_t              out_tag
);

    localparam int DW = SAMPLE_BITS + 1;
    localparam int AW = SAMPLE_BITS + FRAC_BITS + 2;
    localparam int MW = SAMPLE_BITS + FRAC_BITS + 7;
    localparam int QW = MW - FRAC_BITS;
    localparam logic [AW-1:0] HALF_A =
        {{(AW-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};
    localparam logic [MW-1:0] HALF_M =
        {{(MW-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};

    logic en;

    logic                   v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    lirs_tag_t              tag1_reg, tag2_reg, tag3_reg, tag4_reg, tag5_reg;
    logic [SAMPLE_BITS-1:0] left1_reg, left2_reg;
    logic signed [DW-1:0]   diff1_reg;
    logic [FRAC_BITS-1:0]   frac1_reg;
    logic signed [AW-1:0]   prod2_reg;
    logic signed [DW-1:0]   r3_reg;
    logic signed [MW-1:0]   m4_reg;
    logic [SAMPLE_BITS-1:0] out5_reg;

    logic signed [DW-1:0]   diff;
    logic signed [AW-1:0]   acc;
    logic signed [MW-1:0]   rnd_m;
    logic signed [QW-1:0]   q;
    logic [SAMPLE_BITS-1:0] sat;
    logic                   fits;

    // whole pipe freezes while the output word waits
    assign en      = !v5_reg || out_ready;
    assign cmd_pop = en && !cmd_empty;

    assign diff = $signed({cmd_right[SAMPLE_BITS-1], cmd_right})
                - $signed({cmd_left[SAMPLE_BITS-1], cmd_left});

    // left*2^F + frac*(right-left) + half, then floor by 2^F
    assign acc = $signed({{2{left2_reg[SAMPLE_BITS-1]}}, left2_reg, {FRAC_BITS{1'b0}}})
               + prod2_reg + $signed(HALF_A);

    assign rnd_m = m4_reg + $signed(HALF_M);
    assign q     = rnd_m[MW-1:FRAC_BITS];
    assign fits  = (q[QW-1:SAMPLE_BITS-1] == '0) || (q[QW-1:SAMPLE_BITS-1] == '1);
    assign sat   = fits ? q[SAMPLE_BITS-1:0]
                 : (q[QW-1] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}}
                            : {1'b0, {(SAMPLE_BITS-1){1'b1}}});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= cmd_pop;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            left1_reg <= cmd_left;
            diff1_reg <= diff;
            frac1_reg <= cmd_frac;
            tag1_reg  <= cmd_tag;

            left2_reg <= left1_reg;
            prod2_reg <= AW'(diff1_reg * $signed({1'b0, frac1_reg}));
            tag2_reg  <= tag1_reg;

            r3_reg    <= acc[FRAC_BITS+DW-1:FRAC_BITS];
            tag3_reg  <= tag2_reg;

            m4_reg    <= MW'(r3_reg * $signed({1'b0, step}));
            tag4_reg  <= tag3_reg;

            out5_reg  <= sat;
            tag5_reg  <= tag4_reg;
        end
    end

    assign out_valid  = v5_reg;
    assign out_sample = out5_reg;
    assign out_tag    = tag5_reg;

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the linear interpolation resampler.
//
// Directed table first: reset defaults, full-scale samples, saturation at the
// largest step, zero target length, step zero with the result cap, maximum
// upsampling, source length zero, maximum downsampling. Then random phases,
// each one a register set followed mostly by whole source blocks with random
// content. Every accepted source word runs through a local resampling model,
// and its expected output words are queued and compared field by field on exit.
module tb
    import lirs_pkg::*;
;

    localparam int SAMPLE_W   = 24;
    localparam int FRAC_W     = 16;
    localparam int LEN_W      = 16;
    localparam int STEP_W     = FRAC_W + 5;
    localparam int HOLD_OFF   = 64;     // issue + queue + pipe, rounded up
    localparam int IDLE_LIMIT = 2000;   // cycles without any handshake
    localparam int RANDOM_WORDS = 370;

    localparam longint UNITY      = 64'sd1 << FRAC_W;
    localparam longint HALF_LSB   = 64'sd1 << (FRAC_W - 1);
    localparam longint SAMPLE_MAX = (64'sd1 << (SAMPLE_W - 1)) - 1;
    localparam longint SAMPLE_MIN = -(64'sd1 << (SAMPLE_W - 1));
    localparam longint POS_MAX    = (64'sd1 << (LEN_W + FRAC_W)) - 1;

    logic                     aclk      = 1'b0;
    logic                     aresetn   = 1'b0;
    logic                     s_tvalid  = 1'b0;
    logic                     s_tready;
    logic [SAMPLE_W-1:0]      s_tdata   = '0;   // sample_in
    logic                     m_tvalid;
    logic                     m_tready  = 1'b0;
    logic [SAMPLE_W-1:0]      m_tdata;          // sample_out
    logic                     m_tlast;          // run_last
    logic                     m_tuser;          // block_done
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [STEP_W-1:0]        cfg_data  = '0;

    linear_interp_resampler dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // One output word as it should leave the block.
    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                run_last;
        logic                block_done;
    } out_word_t;

    // Row of the directed table: a register write or a source word. A source
    // word may carry a typed-in output (single word, both marks set).
    typedef struct packed {
        logic                is_reg;
        lirs_reg_idx_t       idx;
        logic [SAMPLE_W-1:0] value;
        logic                typed;
        logic [SAMPLE_W-1:0] want;
    } vec_row_t;

    out_word_t due_samples[$];
    int        failures   = 0;
    int        words_sent = 0;
    logic      calm       = 1'b0;   // no idling on either side while set

    // Register shadow and converter state of the local model.
    logic [STEP_W-1:0]          rate_step;
    logic [LEN_W-1:0]           src_len;
    logic [LEN_W-1:0]           tgt_len;
    logic signed [SAMPLE_W-1:0] last_sample;
    logic [LEN_W-1:0]           in_count;
    logic [LEN_W+FRAC_W-1:0]    read_pos;
    logic [LEN_W-1:0]           out_count;

    // (1-frac)*left + frac*right, rounded, scaled by step, rounded, saturated.
    function automatic logic [SAMPLE_W-1:0] blend(input longint left, input longint right,
                                                  input longint frac);
        longint acc;
        longint whole;
        longint scaled;
        acc    = (UNITY - frac) * left + frac * right;
        whole  = (acc + HALF_LSB) >>> FRAC_W;
        scaled = (whole * longint'(rate_step) + HALF_LSB) >>> FRAC_W;
        if (scaled > SAMPLE_MAX) begin
            scaled = SAMPLE_MAX;
        end else if (scaled < SAMPLE_MIN) begin
            scaled = SAMPLE_MIN;
        end
        return scaled[SAMPLE_W-1:0];
    endfunction

    function automatic void step_position();
        longint p;
        p = longint'(read_pos) + longint'(rate_step);
        read_pos = (p > POS_MAX) ? POS_MAX[LEN_W+FRAC_W-1:0] : p[LEN_W+FRAC_W-1:0];
    endfunction

    function automatic void emit(input logic [SAMPLE_W-1:0] v);
        out_count++;
        due_samples.insert(due_samples.size(), out_word_t'{v, 1'b0, out_count >= tgt_len});
    endfunction

    // Queues the output words one source word causes; returns their number.
    function automatic int resample_word(input logic [SAMPLE_W-1:0] word);
        longint cur;
        longint n;
        longint idx;
        logic   final_word;
        int     k;
        cur        = signed'(word);
        n          = in_count;
        final_word = (n + 1 >= longint'(src_len));
        k          = 0;
        // positions that sit between the previous and this sample
        while (k < MAX_RESULTS && out_count < tgt_len && longint'(read_pos >> FRAC_W) < n) begin
            emit(blend(last_sample, cur, read_pos[FRAC_W-1:0]));
            step_position();
            k++;
        end
        if (final_word) begin
            // tail: zero right neighbor, then zero padding to the target length
            while (k < MAX_RESULTS && out_count < tgt_len) begin
                idx = read_pos >> FRAC_W;
                if (idx < n) begin
                    emit(blend(last_sample, cur, read_pos[FRAC_W-1:0]));
                    step_position();
                end else if (idx == n) begin
                    emit(blend(cur, 0, read_pos[FRAC_W-1:0]));
                    step_position();
                end else begin
                    emit('0);
                end
                k++;
            end
            if (k > 0) due_samples[$].block_done = 1'b1;
            last_sample = '0;
            in_count    = '0;
            read_pos    = '0;
            out_count   = '0;
        end else begin
            last_sample = word;
            in_count    = in_count + 1'b1;
        end
        if (k > 0) due_samples[$].run_last = 1'b1;
        return k;
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2: return 24'($urandom_range(0, 511)) - 24'd256;
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic send_word(input logic [SAMPLE_W-1:0] word, input logic typed,
                             input logic [SAMPLE_W-1:0] want);
        int k;
        while (!calm && $urandom_range(0, 99) < 31) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        do @(posedge aclk); while (!s_tready);
        k = resample_word(word);
        if (typed) begin
            repeat (k) void'(due_samples.pop_back());
            due_samples.insert(due_samples.size(), out_word_t'{want, 1'b1, 1'b1});
        end
        words_sent++;
        calm <= (words_sent >= 150 && words_sent < 250);
    endtask

    // Registers change only once the block has gone quiet.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (due_samples.size() != 0) @(posedge aclk);
        repeat (HOLD_OFF) @(posedge aclk);
    endtask

    task automatic write_reg(input lirs_reg_idx_t idx, input logic [STEP_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_STEP:    rate_step = value;
            REG_SRC_LEN: src_len   = value[LEN_W-1:0];
            REG_TGT_LEN: tgt_len   = value[LEN_W-1:0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Result side: random stalls, compare each accepted word with the oldest
    // expectation.
    always @(posedge aclk) begin
        out_word_t exp_word;
        if (aresetn && m_tvalid && m_tready) begin
            if (due_samples.size() == 0) begin
                $error("unexpected output word: sample_out %h run_last %b block_done %b",
                       m_tdata, m_tlast, m_tuser);
                failures++;
            end else begin
                exp_word = due_samples.pop_front();
                if (m_tdata !== exp_word.sample) begin
                    $error("sample_out: expected %h, actual %h", exp_word.sample, m_tdata);
                    failures++;
                end
                if (m_tlast !== exp_word.run_last) begin
                    $error("run_last: expected %b, actual %b", exp_word.run_last, m_tlast);
                    failures++;
                end
                if (m_tuser !== exp_word.block_done) begin
                    $error("block_done: expected %b, actual %b", exp_word.block_done, m_tuser);
                    failures++;
                end
            end
        end
        m_tready <= calm || ($urandom_range(0, 99) >= 31);
    end

    // Watchdog: ends the run once nothing has moved on any channel for too long.
    int idle_cycles = 0;
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        vec_row_t          vectors [0:36];
        logic              dirty;
        logic [STEP_W-1:0] new_step;
        logic [LEN_W-1:0]  new_src;
        longint            nominal;
        longint            new_tgt;
        int                n_words;

        vectors = '{
            // reset defaults: step 1.0, one-sample blocks, copy through
            '{1'b0, REG_STEP, 24'h7FFFFF, 1'b1, 24'h7FFFFF},
            '{1'b0, REG_STEP, 24'h800000, 1'b1, 24'h800000},
            '{1'b0, REG_STEP, 24'h000000, 1'b1, 24'h000000},
            '{1'b0, REG_STEP, 24'h000001, 1'b1, 24'h000001},
            // largest step: scaled result saturates
            '{1'b1, REG_STEP,    24'h1FFFFF, 1'b0, 24'h0},
            '{1'b1, REG_SRC_LEN, 24'd2,      1'b0, 24'h0},
            '{1'b1, REG_TGT_LEN, 24'd3,      1'b0, 24'h0},
            '{1'b0, REG_STEP, 24'h400000, 1'b0, 24'h0},
            '{1'b0, REG_STEP, 24'hC00000, 1'b0, 24'h0},
            // zero target length: silent, blocks still rearm
            '{1'b1, REG_TGT_LEN, 24'd0,      1'b0, 24'h0},
            '{1'b0, REG_STEP, 24'h7FFFFF, 1'b0, 24'h0},
            '{1'b0, REG_STEP, 24'h800000, 1'b0, 24'h0},
            // step zero: position stuck, result cap on every word after the first
            '{1'b1, REG_STEP,    24'd0,      1'b0, 24'h0},
            '{1'b1, REG_SRC_LEN, 24'd3,      1'b0, 24'h0},
            '{1'b1, REG_TGT_LEN, 24'hFFFF,   1'b0, 24'h0},
            '{1'b0, REG_STEP, 24'h123456, 1'b0, 24'h0},
            '{1'b0, REG_STEP, 24'h800000, 1'b0, 24'h0},
            '{1'b0, REG_STEP, 24'h7FFFFF, 1'b0, 24'h0},
            // maximum upsampling, sixteen outputs per source sample interval
            '{1'b1, REG_STEP,    24'd4096,   1'b0, 24'h0},
            '{1'b1, REG_SRC_LEN, 24'd4,      1'b0, 24'h0},
            '{1'b1, REG_TGT_LEN, 24'd64,     1'b0, 24'h0},
            '{1'b0, REG_STEP, 24'h7FFFFF, 1'b0, 24'h0},
            '{1'b0, REG_STEP, 24'h800000, 1'b0, 24'h0},
            '{1'b0, REG_STEP, 24'h7FFFFF, 1'b0, 24'h0},
            '{1'b0, REG_STEP, 24'h000000, 1'b0, 24'h0},
            // source length zero: every word closes its block
            '{1'b1, REG_STEP,    24'd65536,  1'b0, 24'h0},
            '{1'b1, REG_SRC_LEN, 24'd0,      1'b0, 24'h0},
            '{1'b1, REG_TGT_LEN, 24'd1,      1'b0, 24'h0},
            '{1'b0, REG_STEP, 24'hFFFFFF, 1'b1, 24'hFFFFFF},
            // maximum downsampling
            '{1'b1, REG_STEP,    24'd1048576, 1'b0, 24'h0},
            '{1'b1, REG_SRC_LEN, 24'd5,       1'b0, 24'h0},
            '{1'b1, REG_TGT_LEN, 24'd1,       1'b0, 24'h0},
            '{1'b0, REG_STEP, 24'h555555, 1'b0, 24'h0},
            '{1'b0, REG_STEP, 24'hAAAAAA, 1'b0, 24'h0},
            '{1'b0, REG_STEP, 24'h7FFFFF, 1'b0, 24'h0},
            '{1'b0, REG_STEP, 24'h800000, 1'b0, 24'h0},
            '{1'b0, REG_STEP, 24'h0F0F0F, 1'b0, 24'h0}
        };

        rate_step   = STEP_W'(UNITY);
        src_len     = 1;
        tgt_len     = 1;
        last_sample = '0;
        in_count    = '0;
        read_pos    = '0;
        out_count   = '0;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        dirty = 1'b0;
        foreach (vectors[i]) begin
            if (vectors[i].is_reg) begin
                if (dirty) drain_results();
                dirty = 1'b0;
                write_reg(vectors[i].idx, vectors[i].value[STEP_W-1:0]);
            end else begin
                send_word(vectors[i].value, vectors[i].typed, vectors[i].want);
                dirty = 1'b1;
            end
        end

        // Random phases: quiet the block, set all three registers, then whole blocks;
        // a source length of 0 or over 24, or one draw in five, gives a ragged word count.
        while (words_sent < RANDOM_WORDS - 10) begin
            drain_results();
            case ($urandom_range(0, 11))
                0: new_step = '0;
                1: new_step = '1;
                2: new_step = 21'd4096;
                3: new_step = 21'd1048576;
                4: new_step = 21'd65536;
                default: new_step = STEP_W'($urandom_range(4096, 1048576));
            endcase
            case ($urandom_range(0, 9))
                0: new_src = '0;
                1: new_src = '1;
                2: new_src = LEN_W'($urandom);
                default: new_src = LEN_W'($urandom_range(1, 12));
            endcase
            if (new_step == 0) begin
                nominal = 40;
            end else begin
                nominal = (longint'(new_src) * UNITY + longint'(new_step) / 2)
                          / longint'(new_step);
            end
            case ($urandom_range(0, 9))
                0: new_tgt = 0;
                1: new_tgt = 65535;
                2: new_tgt = $urandom_range(0, 65535);
                3: new_tgt = nominal + 1;
                default: new_tgt = nominal;
            endcase
            if (new_tgt > 65535) new_tgt = 65535;
            write_reg(REG_STEP, new_step);
            write_reg(REG_SRC_LEN, STEP_W'(new_src));
            write_reg(REG_TGT_LEN, STEP_W'(new_tgt));

            if (new_src >= 1 && new_src <= 24 && $urandom_range(0, 4) != 0) begin
                // finish a block left open by an earlier phase, then whole ones
                n_words = (in_count < new_src) ? int'(new_src - in_count) : 1;
                n_words += int'(new_src) * $urandom_range(1, 4);
            end else begin
                n_words = $urandom_range(1, 12);
            end
            repeat (n_words) send_word(pick_sample(), 1'b0, '0);
        end

        drain_results();
        if (due_samples.size() != 0) begin
            $error("%0d expected output words never arrived", due_samples.size());
            failures++;
        end
        if (failures == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/lirs_pkg.sv
hw/rtl/lirs_cmd_fifo.sv
hw/rtl/lirs_front.sv
hw/rtl/lirs_back.sv
hw/rtl/linear_interp_resampler.sv
tb/tb.sv
